// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion macros used by the top-level RTL file of the 3x3 inverse block.
// Clocked checks, with and without a reset guard.

// Concurrent check, disabled while reset is high
`define MI3_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// Concurrent check that also holds during reset
`define MI3_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) (prop)) else $error(msg);

`endif

// ===== rtl/core/mi3_pkg.sv =====
// Package for the 3x3 matrix inverse block: default element format.
// No dependencies.
`default_nettype none

package mi3_pkg;

  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF     = 16;

endpackage

`default_nettype wire

// ===== rtl/core/matrix3x3_inverse_top.sv =====
// Pipelined 3x3 matrix inverse by adjugate over determinant.
// Depends on mi3_pkg and assert_macros.svh.
`default_nettype none

// A new matrix is taken on every clock edge at which start is high; busy is
// always low, so one matrix may follow another in every cycle. Each result
// appears on the inv_* ports with done high for exactly one cycle, and must be
// captured then: the block has no way to hold results back. The depth is set
// by the quotient unit, which resolves one quotient bit per stage for nine
// entries side by side, ahead of which sit seven stages of products, cofactors
// and determinant. A zero determinant gives all-zero entries with singular set;
// out-of-range entries are clipped and flagged by saturated.
module matrix3x3_inverse_top #(
  parameter int ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH_DEF,
  parameter int FRAC_BITS     = mi3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m_r0c0,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m_r0c1,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m_r0c2,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m_r1c0,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m_r1c1,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m_r1c2,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m_r2c0,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m_r2c1,
  input  wire logic signed [ELEMENT_WIDTH-1:0] m_r2c2,
  output logic                                 done,
  output logic signed [ELEMENT_WIDTH-1:0]      inv_r0c0,
  output logic signed [ELEMENT_WIDTH-1:0]      inv_r0c1,
  output logic signed [ELEMENT_WIDTH-1:0]      inv_r0c2,
  output logic signed [ELEMENT_WIDTH-1:0]      inv_r1c0,
  output logic signed [ELEMENT_WIDTH-1:0]      inv_r1c1,
  output logic signed [ELEMENT_WIDTH-1:0]      inv_r1c2,
  output logic signed [ELEMENT_WIDTH-1:0]      inv_r2c0,
  output logic signed [ELEMENT_WIDTH-1:0]      inv_r2c1,
  output logic signed [ELEMENT_WIDTH-1:0]      inv_r2c2,
  output logic                                 singular,
  output logic                                 saturated
);

  localparam int W   = ELEMENT_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;            // element product
  localparam int CW  = 2 * W + 1;        // cofactor
  localparam int LW  = W;                // low slice of a cofactor
  localparam int HW  = CW - LW;          // high slice of a cofactor
  localparam int PPH = W + HW;           // partial product, high slice
  localparam int PPL = W + LW + 1;       // partial product, low slice
  localparam int DW  = 3 * W + 3;        // determinant
  localparam int NW  = CW + 2 * F;       // scaled numerator magnitude
  localparam int QB  = W + 1;            // quotient bits resolved
  localparam int UW  = (NW > DW + QB) ? NW : DW + QB;  // remainder
  localparam int L   = QB + 1;           // last quotient stage
  localparam int LAT = QB + 9;           // accept edge to result sample

  function automatic logic [CW-1:0] abs_cof(input logic signed [CW-1:0] x);
    return x[CW-1] ? CW'(-x) : CW'(x);
  endfunction

  function automatic logic [DW-1:0] abs_det(input logic signed [DW-1:0] x);
    return x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

  // Stage registers
  logic signed [W-1:0]   m0   [9];
  logic                  v0;
  logic signed [PW-1:0]  pa1  [9];
  logic signed [PW-1:0]  pb1  [9];
  logic signed [W-1:0]   row1 [3];
  logic                  v1;
  logic signed [CW-1:0]  cof2 [9];
  logic signed [W-1:0]   row2 [3];
  logic                  v2;
  logic signed [PPH-1:0] ph3  [3];
  logic signed [PPL-1:0] pl3  [3];
  logic signed [CW-1:0]  cof3 [9];
  logic                  v3;
  logic signed [DW-1:0]  term4 [3];
  logic signed [CW-1:0]  cof4 [9];
  logic                  v4;
  logic signed [DW-1:0]  det5;
  logic signed [CW-1:0]  cof5 [9];
  logic                  v5;

  // Quotient pipeline, stage 0 is loaded from stage 5
  logic [UW-1:0] rem [L+1][9];
  logic [DW-1:0] dv  [L+1];
  logic          ng  [L+1][9];
  logic          sg  [L+1];
  logic          vs  [L+1];
  logic [QB-1:0] qq  [1:L][9];
  logic          ov  [1:L][9];

  // Output stage
  logic signed [W-1:0] lane_val [9];
  logic                lane_sat [9];
  logic signed [W-1:0] outv     [9];

  assign busy = 1'b0;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      v5    <= 1'b0;
      vs[0] <= 1'b0;
    end else begin
      v0    <= start;
      v1    <= v0;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      vs[0] <= v5;
    end
  end

  // Capture the transfer
  always_ff @(posedge clk) begin
    m0[0] <= m_r0c0;
    m0[1] <= m_r0c1;
    m0[2] <= m_r0c2;
    m0[3] <= m_r1c0;
    m0[4] <= m_r1c1;
    m0[5] <= m_r1c2;
    m0[6] <= m_r2c0;
    m0[7] <= m_r2c1;
    m0[8] <= m_r2c2;
  end

  // Form the two minor products of every cofactor
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int A = ((i + 1) % 3) * 3 + (j + 1) % 3;
      localparam int B = ((i + 2) % 3) * 3 + (j + 2) % 3;
      localparam int C = ((i + 1) % 3) * 3 + (j + 2) % 3;
      localparam int D = ((i + 2) % 3) * 3 + (j + 1) % 3;
      always_ff @(posedge clk) begin
        pa1[i*3+j] <= PW'(m0[A]) * PW'(m0[B]);
        pb1[i*3+j] <= PW'(m0[C]) * PW'(m0[D]);
      end
    end
  end

  // Subtract into cofactors, then form the row-0 products in slices and sum them into the determinant
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      row1[k] <= m0[k];
      row2[k] <= row1[k];
      ph3[k]  <= PPH'(row2[k]) * PPH'($signed(cof2[k][CW-1:LW]));
      pl3[k]  <= PPL'(row2[k]) * PPL'($signed({1'b0, cof2[k][LW-1:0]}));
      term4[k] <= (DW'(ph3[k]) <<< LW) + DW'(pl3[k]);
    end
    for (int k = 0; k < 9; k++) begin
      cof2[k] <= CW'(pa1[k]) - CW'(pb1[k]);
      cof3[k] <= cof2[k];
      cof4[k] <= cof3[k];
      cof5[k] <= cof4[k];
    end
    det5 <= term4[0] + term4[1] + term4[2];
  end

  // Take magnitudes and signs ahead of the quotient unit
  always_ff @(posedge clk) begin
    dv[0] <= abs_det(det5);
    sg[0] <= (det5 == '0);
    for (int k = 0; k < 9; k++) begin
      rem[0][k] <= UW'(abs_cof(cof5[k])) << (2 * F);
      ng[0][k]  <= cof5[k][CW-1] ^ det5[DW-1];
    end
  end

  // Quotient stages: an overflow check, then one bit per stage
  for (genvar s = 1; s <= L; s++) begin : g_div
    localparam int K = L - s;
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[s] <= 1'b0;
      end else begin
        vs[s] <= vs[s-1];
      end
    end
    if (s == 1) begin : g_ovf
      always_ff @(posedge clk) begin
        dv[s] <= dv[s-1];
        sg[s] <= sg[s-1];
        for (int k = 0; k < 9; k++) begin
          rem[s][k] <= rem[s-1][k];
          ng[s][k]  <= ng[s-1][k];
          qq[s][k]  <= '0;
          ov[s][k]  <= rem[s-1][k] >= (UW'(dv[s-1]) << QB);
        end
      end
    end else begin : g_bit
      logic [UW-1:0] shd;
      logic [UW:0]   diff [9];
      assign shd = UW'(dv[s-1]) << K;
      always_comb begin
        for (int k = 0; k < 9; k++) begin
          diff[k] = {1'b0, rem[s-1][k]} - {1'b0, shd};
        end
      end
      always_ff @(posedge clk) begin
        dv[s] <= dv[s-1];
        sg[s] <= sg[s-1];
        for (int k = 0; k < 9; k++) begin
          rem[s][k] <= diff[k][UW] ? rem[s-1][k] : diff[k][UW-1:0];
          qq[s][k]  <= {qq[s-1][k][QB-2:0], ~diff[k][UW]};
          ng[s][k]  <= ng[s-1][k];
          ov[s][k]  <= ov[s-1][k];
        end
      end
    end
  end

  // Apply sign and clip to the element range
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      lane_sat[k] = ov[L][k] ||
                    (ng[L][k] ? (qq[L][k] > (QB'(1) << (W - 1)))
                              : (qq[L][k] >= (QB'(1) << (W - 1))));
      if (lane_sat[k]) begin
        lane_val[k] = ng[L][k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        lane_val[k] = ng[L][k] ? -$signed(qq[L][k][W-1:0]) : $signed(qq[L][k][W-1:0]);
      end
    end
  end

  // Register the result; entry (r,c) comes from cofactor (c,r)
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vs[L];
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        outv[r*3+c] <= sg[L] ? '0 : lane_val[c*3+r];
      end
    end
    singular  <= sg[L];
    saturated <= !sg[L] && (lane_sat[0] || lane_sat[1] || lane_sat[2] ||
                            lane_sat[3] || lane_sat[4] || lane_sat[5] ||
                            lane_sat[6] || lane_sat[7] || lane_sat[8]);
  end

  assign inv_r0c0 = outv[0];
  assign inv_r0c1 = outv[1];
  assign inv_r0c2 = outv[2];
  assign inv_r1c0 = outv[3];
  assign inv_r1c1 = outv[4];
  assign inv_r1c2 = outv[5];
  assign inv_r2c0 = outv[6];
  assign inv_r2c1 = outv[7];
  assign inv_r2c2 = outv[8];

`include "assert_macros.svh"

  `MI3_ASSERT(a_done_from_transfer, clk, rst, done |-> $past(start && !busy, LAT), "result without transfer")
  `MI3_ASSERT(a_div_depth, clk, rst, vs[0] |-> ##(QB + 2) done, "quotient pipeline lost an item")
  `MI3_ASSERT_ALWAYS(a_singular_clean, clk, (done && singular) |-> !saturated, "singular result flagged as clipped")

endmodule

`default_nettype wire
